// ===== hdl/mftp_pkg.sv =====
// shared types and constants for the multilevel feedback task picker
package mftp_pkg;

    localparam int ACTION_W    = 2;
    localparam int ID_W        = 4;
    localparam int RUN_LEVEL_W = 3;
    localparam int QUANTUM_W   = 30;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_QREGS   = 5;

    localparam logic [ACTION_W-1:0] ACT_NEW   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_YIELD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd2;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET [NUM_QREGS] = '{
        30'd10000000, 30'd20000000, 30'd40000000, 30'd80000000, 30'd160000000
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic push_en;
        logic pop_en;
        logic full_cap;
        logic lvl_write;
        logic load_direct;
        logic load_pop;
    } ctl_t;

endpackage

// ===== hdl/multilevel_feedback_task_picker.sv =====
// top level of the multilevel feedback task picker
//
// Command channel: an event (action, task_id) is taken on a clock edge with
// start high and busy low. busy stays high while the event is worked on.
// Every event gives exactly one result: run_task, run_level, quantum_ns and
// queue_full are shown for one cycle with done high; the receiver cannot
// stall, so a result is never held.
// A start event (or any action other than new or yield), or a new task that
// finds level 0 empty, is answered straight from the push step. A yield, or a
// new task queued behind others, goes through a push step, a pop step and a
// load step for the registered read of the queue ram, with its single read and
// write port. A new event may be accepted in the cycle that shows done.
// Configuration: quantum registers are written over cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is low while busy, so writes are taken
// only while the block is idle, indexes past the last register are dropped.
// Reset clears all task levels and queue pointers and loads the default
// quanta; the queue ram needs no clearing since it is read only after a push.
module multilevel_feedback_task_picker #(
    parameter int TASKS  = 16,
    parameter int LEVELS = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mftp_pkg::ACTION_W-1:0]      action,
    input  logic [mftp_pkg::ID_W-1:0]          task_id,
    output logic                               done,
    output logic [mftp_pkg::ID_W-1:0]          run_task,
    output logic [mftp_pkg::RUN_LEVEL_W-1:0]   run_level,
    output logic [mftp_pkg::QUANTUM_W-1:0]     quantum_ns,
    output logic                               queue_full,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mftp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mftp_pkg::QUANTUM_W-1:0]     cfg_data
);

    localparam int LVL_W    = $clog2(LEVELS);
    localparam int PTR_W    = $clog2(TASKS);
    localparam int CNT_W    = $clog2(TASKS + 1);
    localparam int DEPTH    = LEVELS * TASKS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ID_SPAN  = 2 ** mftp_pkg::ID_W;
    localparam int TL_DEPTH = (TASKS < ID_SPAN) ? TASKS : ID_SPAN;
    localparam int TL_IW    = $clog2(TL_DEPTH);

    mftp_pkg::state_t state_reg, state_next;
    mftp_pkg::ctl_t   ctl;

    logic [mftp_pkg::ACTION_W-1:0]    action_reg;
    logic [mftp_pkg::ID_W-1:0]        id_reg;
    logic                             full_reg;
    logic [LVL_W-1:0]                 pop_lvl_reg;
    logic [LVL_W-1:0]                 task_level_reg [TL_DEPTH];
    logic [PTR_W-1:0]                 head_reg [LEVELS];
    logic [PTR_W-1:0]                 tail_reg [LEVELS];
    logic [CNT_W-1:0]                 cnt_reg [LEVELS];
    logic [mftp_pkg::QUANTUM_W-1:0]   qreg_reg [mftp_pkg::NUM_QREGS];

    logic                             done_reg;
    logic [mftp_pkg::ID_W-1:0]        run_task_reg;
    logic [mftp_pkg::RUN_LEVEL_W-1:0] run_level_reg;
    logic [mftp_pkg::QUANTUM_W-1:0]   quantum_reg;
    logic                             queue_full_reg;

    logic                             accept;
    logic                             is_new;
    logic                             is_yield;
    logic                             id_ok;
    logic                             q0_busy;
    logic                             pushing;
    logic                             found;
    logic [LVL_W-1:0]                 lvl_cur;
    logic [LVL_W-1:0]                 next_lvl;
    logic [LVL_W-1:0]                 push_lvl;
    logic [LVL_W-1:0]                 pop_lvl_sel;
    logic [LVL_W-1:0]                 unit_lvl;
    logic [PTR_W-1:0]                 unit_ptr;
    logic [PTR_W-1:0]                 unit_inc;
    logic [CNT_W-1:0]                 unit_cnt;
    logic                             unit_full;
    logic [ADDR_W-1:0]                unit_addr;
    logic [mftp_pkg::ID_W-1:0]        ram_rdata;
    logic [mftp_pkg::QUANTUM_W-1:0]   pop_quantum;

    assign busy      = (state_reg != mftp_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;

    assign done       = done_reg;
    assign run_task   = run_task_reg;
    assign run_level  = run_level_reg;
    assign quantum_ns = quantum_reg;
    assign queue_full = queue_full_reg;

    // event decode and level bookkeeping
    assign is_new   = (action_reg == mftp_pkg::ACT_NEW);
    assign is_yield = (action_reg == mftp_pkg::ACT_YIELD);
    assign id_ok    = (int'(id_reg) < TASKS);
    assign lvl_cur  = id_ok ? task_level_reg[id_reg[TL_IW-1:0]] : '0;
    assign next_lvl = (int'(lvl_cur) < LEVELS - 1) ? lvl_cur + LVL_W'(1)
                                                   : LVL_W'(LEVELS - 1);
    assign push_lvl = is_yield ? next_lvl : '0;
    assign q0_busy  = (cnt_reg[0] != '0);
    assign pushing  = is_yield || (is_new && q0_busy);

    // first non-empty level
    always_comb
    begin
        pop_lvl_sel = push_lvl;
        found       = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (!found && cnt_reg[i] != '0)
            begin
                pop_lvl_sel = LVL_W'(i);
                found       = 1'b1;
            end
        end
    end

    // shared pointer and address unit, used for push then pop
    always_comb
    begin
        unit_lvl  = (state_reg == mftp_pkg::ST_POP) ? pop_lvl_sel : push_lvl;
        unit_ptr  = (state_reg == mftp_pkg::ST_POP) ? head_reg[unit_lvl] : tail_reg[unit_lvl];
        unit_cnt  = cnt_reg[unit_lvl];
        unit_full = (unit_cnt >= CNT_W'(TASKS));
        unit_inc  = (unit_ptr == PTR_W'(TASKS - 1)) ? '0 : unit_ptr + PTR_W'(1);
        unit_addr = ADDR_W'(int'(unit_lvl) * TASKS + int'(unit_ptr));
    end

    assign pop_quantum = (int'(pop_lvl_reg) >= mftp_pkg::NUM_QREGS)
                       ? qreg_reg[mftp_pkg::NUM_QREGS-1]
                       : qreg_reg[pop_lvl_reg];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mftp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mftp_pkg::ST_PUSH;
                end
            end
            mftp_pkg::ST_PUSH:
            begin
                state_next = pushing ? mftp_pkg::ST_POP : mftp_pkg::ST_IDLE;
            end
            mftp_pkg::ST_POP:
            begin
                state_next = mftp_pkg::ST_LOAD;
            end
            mftp_pkg::ST_LOAD:
            begin
                state_next = mftp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mftp_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer controls
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            mftp_pkg::ST_PUSH:
            begin
                ctl.push_en     = pushing && !unit_full;
                ctl.full_cap    = 1'b1;
                ctl.lvl_write   = (is_new || is_yield) && id_ok;
                ctl.load_direct = !pushing;
            end
            mftp_pkg::ST_POP:
            begin
                ctl.pop_en = 1'b1;
            end
            mftp_pkg::ST_LOAD:
            begin
                ctl.load_pop = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    mftp_ram #(
        .WIDTH (mftp_pkg::ID_W),
        .DEPTH (DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ctl.push_en),
        .waddr (unit_addr),
        .wdata (id_reg),
        .raddr (unit_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mftp_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < TL_DEPTH; i++)
            begin
                task_level_reg[i] <= '0;
            end
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            for (int i = 0; i < mftp_pkg::NUM_QREGS; i++)
            begin
                qreg_reg[i] <= mftp_pkg::QUANTUM_RESET[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctl.load_direct || ctl.load_pop;
            if (cfg_valid && cfg_ready && int'(cfg_index) < mftp_pkg::NUM_QREGS)
            begin
                qreg_reg[cfg_index] <= cfg_data;
            end
            if (ctl.lvl_write)
            begin
                task_level_reg[id_reg[TL_IW-1:0]] <= is_yield ? next_lvl : '0;
            end
            if (ctl.push_en)
            begin
                tail_reg[unit_lvl] <= unit_inc;
                cnt_reg[unit_lvl]  <= unit_cnt + CNT_W'(1);
            end
            if (ctl.pop_en)
            begin
                head_reg[unit_lvl] <= unit_inc;
                cnt_reg[unit_lvl]  <= unit_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            id_reg     <= task_id;
        end
        if (ctl.full_cap)
        begin
            full_reg <= pushing && unit_full;
        end
        if (ctl.pop_en)
        begin
            pop_lvl_reg <= unit_lvl;
        end
        if (ctl.load_direct)
        begin
            run_task_reg   <= id_reg;
            run_level_reg  <= is_new ? '0 : mftp_pkg::RUN_LEVEL_W'(lvl_cur);
            quantum_reg    <= is_new ? qreg_reg[0] : '0;
            queue_full_reg <= 1'b0;
        end
        if (ctl.load_pop)
        begin
            run_task_reg   <= ram_rdata;
            run_level_reg  <= mftp_pkg::RUN_LEVEL_W'(pop_lvl_reg);
            quantum_reg    <= pop_quantum;
            queue_full_reg <= full_reg;
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == mftp_pkg::ST_PUSH)
        else $error("accepted event did not enter push step");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mftp_pkg::ST_POP |-> cnt_reg[pop_lvl_sel] != '0)
        else $error("pop from empty queue");

    a_full_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done && queue_full |-> $past(state_reg) == mftp_pkg::ST_LOAD)
        else $error("queue full flag on a result without insert");

endmodule

// ===== hdl/mftp_ram.sv =====
// generic single write port ram with registered read
module mftp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
